### hdl/cfof_pkg.sv
package cfof_pkg;

   localparam int WORD_W = 16;
   localparam int OCC_W  = 4;

   typedef enum logic {
      CMD_PUSH = 1'b0,
      CMD_POP  = 1'b1
   } command_type;

   typedef enum logic {
      STATUS_OK  = 1'b0,
      STATUS_ERR = 1'b1
   } status_type;

   // Per-cell control: load takes the pushed word, shift takes the upper neighbor.
   typedef struct packed {
      logic shift;
      logic load;
   } cell_ctrl_type;

endpackage

### hdl/change_filtered_overwrite_fifo_core.sv
// Channel   Direction  Handshake               Payload
// req       in         req_tvalid/req_tready   tuser: command, tdata: buttons
// rsp       out        rsp_tvalid/rsp_tready   tuser: status, tdata: popped_word, occupancy
//
// One request is taken per cycle; its response is registered and appears in the next cycle.
// The words sit in a row of cells with the oldest in cell 0; a pop or a push into a full
// queue shifts every cell down by one in the same cycle, so no request waits on another.
// A stalled response holds the output register and blocks new requests only while it waits.
// Reset clears the count, the last pushed word and the response valid; cell contents stay.
module change_filtered_overwrite_fifo_core
   import cfof_pkg::*;
#(
   parameter int QUEUE_DEPTH = 8
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] buttons
   input  logic        req_tuser,   // [0] command
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [15:0] popped_word, [19:16] occupancy, [23:20] zero
   output logic        rsp_tuser    // [0] status
);

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  count_in;
   logic [WORD_W-1:0] last_ff;
   logic [WORD_W-1:0] last_in;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   logic [WORD_W-1:0] rsp_word_ff;
   logic [WORD_W-1:0] rsp_word_in;
   logic [OCC_W-1:0]  rsp_occ_ff;
   logic [OCC_W-1:0]  rsp_occ_in;
   logic              rsp_status_ff;
   logic              rsp_status_in;

   logic              req_fire;
   logic              is_pop;
   logic              is_full;
   logic              push_ok;
   logic              pop_ok;
   logic [WORD_W-1:0] cell_word [QUEUE_DEPTH];
   cell_ctrl_type     cell_ctrl [QUEUE_DEPTH];

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;
   assign is_pop     = (req_tuser == CMD_POP);
   assign is_full    = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign push_ok    = req_fire && !is_pop && (req_tdata != last_ff);
   assign pop_ok     = req_fire && is_pop && (count_ff != '0);

   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      logic [WORD_W-1:0] neighbor;
      if (i == QUEUE_DEPTH - 1) begin : g_top
         assign neighbor = req_tdata;
      end else begin : g_mid
         assign neighbor = cell_word[i+1];
      end

      // A pop or full push shifts the row down; a full push loads the top cell, else the free cell.
      assign cell_ctrl[i].shift = pop_ok || (push_ok && is_full);
      assign cell_ctrl[i].load  = push_ok &&
                                  (is_full ? (i == QUEUE_DEPTH - 1) : (count_ff == CNT_W'(i)));

      cfof_cell u_cell (
         .clock         (clock),
         .ctrl          (cell_ctrl[i]),
         .push_word     (req_tdata),
         .neighbor_word (neighbor),
         .word          (cell_word[i])
      );
   end

   always_comb begin
      count_in      = count_ff;
      last_in       = last_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_word_in   = rsp_word_ff;
      rsp_occ_in    = rsp_occ_ff;
      rsp_status_in = rsp_status_ff;
      if (push_ok) begin
         last_in = req_tdata;
         if (!is_full) begin
            count_in = count_ff + 1'b1;
         end
      end else if (pop_ok) begin
         count_in = count_ff - 1'b1;
      end
      if (req_fire) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = (push_ok || pop_ok) ? STATUS_OK : STATUS_ERR;
         rsp_word_in   = pop_ok ? cell_word[0] : '0;
         rsp_occ_in    = OCC_W'(count_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         last_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_word_ff   <= rsp_word_in;
      rsp_occ_ff    <= rsp_occ_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {4'b0000, rsp_occ_ff, rsp_word_ff};

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("stored count above queue depth");

   a_empty_pop: assert property (@(posedge clock) disable iff (reset)
      req_fire && is_pop && (count_ff == '0) |=> rsp_valid_ff && (rsp_status_ff == STATUS_ERR))
      else $error("pop from empty queue not flagged");

   a_push_count: assert property (@(posedge clock) disable iff (reset)
      push_ok && !is_full |=> count_ff == $past(count_ff) + 1'b1)
      else $error("push did not raise the count");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_status_ff == STATUS_ERR) |-> rsp_word_ff == '0)
      else $error("error response carries a word");

endmodule

### hdl/cfof_cell.sv
module cfof_cell
   import cfof_pkg::*;
(
   input  logic                clock,
   input  cell_ctrl_type       ctrl,
   input  logic [WORD_W-1:0]   push_word,
   input  logic [WORD_W-1:0]   neighbor_word,
   output logic [WORD_W-1:0]   word
);

   logic [WORD_W-1:0] word_ff;
   logic [WORD_W-1:0] word_in;

   always_comb begin
      word_in = word_ff;
      if (ctrl.load) begin
         word_in = push_word;
      end else if (ctrl.shift) begin
         word_in = neighbor_word;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign word = word_ff;

endmodule

### test/tb_change_filtered_overwrite_fifo_core.sv
module tb_change_filtered_overwrite_fifo_core
   import cfof_pkg::*;
;

   localparam int DEPTH         = 8;
   localparam int IDLE_LIMIT    = 2000;
   localparam int PHASE_ITEMS   = 163;
   localparam int REPORT_LIMIT  = 10;

   typedef struct packed {
      status_type        status;
      logic [WORD_W-1:0] word;
      logic [OCC_W-1:0]  occupancy;
   } response_type;

   typedef struct packed {
      command_type       command;
      logic [WORD_W-1:0] buttons;
      logic              known;
      response_type      result;
   } stimulus_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata  = '0;   // [15:0] buttons
   logic        req_tuser  = 1'b0; // [0] command
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;         // [15:0] popped_word, [19:16] occupancy, [23:20] zero
   logic        rsp_tuser;         // [0] status

   // Shadow of the event queue.
   logic [WORD_W-1:0] saved_words [DEPTH];
   int                head_pos;
   int                tail_pos;
   int                word_count;
   logic [WORD_W-1:0] last_word;

   response_type pending_responses [$];
   stimulus_type directed_rows [$];

   logic         row_known;
   response_type row_result;
   int           idle_pct;
   int           stall_pct;
   int           idle_cycles;
   int           mismatches;
   int           pushes_stored;
   int           pushes_refused;
   int           words_dropped;
   int           pops_done;
   int           pops_empty;

   change_filtered_overwrite_fifo_core #(
      .QUEUE_DEPTH(DEPTH)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic response_type apply_button_event(command_type command,
                                                       logic [WORD_W-1:0] buttons);
      response_type r;
      r.status = STATUS_OK;
      r.word   = '0;
      if (command == CMD_PUSH) begin
         if (buttons == last_word) begin
            r.status = STATUS_ERR;
            pushes_refused++;
         end else begin
            // A full queue loses its oldest word to make room.
            if (word_count >= DEPTH) begin
               head_pos = (head_pos + 1) % DEPTH;
               words_dropped++;
            end else begin
               word_count++;
            end
            saved_words[tail_pos] = buttons;
            tail_pos  = (tail_pos + 1) % DEPTH;
            last_word = buttons;
            pushes_stored++;
         end
      end else begin
         if (word_count == 0) begin
            r.status = STATUS_ERR;
            pops_empty++;
         end else begin
            r.word   = saved_words[head_pos];
            head_pos = (head_pos + 1) % DEPTH;
            word_count--;
            pops_done++;
         end
      end
      r.occupancy = word_count[OCC_W-1:0];
      return r;
   endfunction

   function automatic stimulus_type make_row(command_type c, logic [WORD_W-1:0] b, logic k,
                                             status_type s, logic [WORD_W-1:0] w,
                                             logic [OCC_W-1:0] o);
      stimulus_type row;
      row.command          = c;
      row.buttons          = b;
      row.known            = k;
      row.result.status    = s;
      row.result.word      = w;
      row.result.occupancy = o;
      return row;
   endfunction

   task automatic send_request(command_type command, logic [WORD_W-1:0] buttons,
                               logic known, response_type result);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= command;
      req_tdata  <= buttons;
      row_known  = known;
      row_result = result;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic wait_for_drain();
      req_tvalid <= 1'b0;
      while (pending_responses.size() != 0) @(negedge clock);
   endtask

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= stall_pct);
   end

   // Sample both channels at the rising edge: predict on request, compare on response.
   always @(posedge clock) begin
      response_type expected;
      logic         moved;
      moved = 1'b0;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            moved    = 1'b1;
            expected = apply_button_event(command_type'(req_tuser), req_tdata);
            if (row_known) expected = row_result;
            pending_responses.push_back(expected);
         end
         if (rsp_tvalid && rsp_tready) begin
            moved = 1'b1;
            if (pending_responses.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT)
                  $display("Unexpected response: status %0d word %h occupancy %0d",
                           rsp_tuser, rsp_tdata[15:0], rsp_tdata[19:16]);
            end else begin
               expected = pending_responses.pop_front();
               if (rsp_tuser !== expected.status || rsp_tdata[15:0] !== expected.word ||
                   rsp_tdata[19:16] !== expected.occupancy || rsp_tdata[23:20] !== 4'b0) begin
                  mismatches++;
                  if (mismatches <= REPORT_LIMIT)
                     $display("Mismatch: expected %0d %h %0d, got %0d %h %0d pad %h",
                              expected.status, expected.word, expected.occupancy,
                              rsp_tuser, rsp_tdata[15:0], rsp_tdata[19:16], rsp_tdata[23:20]);
               end
            end
         end
         idle_cycles = moved ? 0 : idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("Watchdog expired with %0d responses outstanding.",
                     pending_responses.size());
            $display("FAIL");
            $finish;
         end
      end
   end

   initial begin
      logic [WORD_W-1:0] prev_word;
      logic [WORD_W-1:0] word;
      int                push_pct;
      int                pick;
      response_type      none;

      for (int i = 0; i < DEPTH; i++) saved_words[i] = '0;
      head_pos       = 0;
      tail_pos       = 0;
      word_count     = 0;
      last_word      = '0;
      mismatches     = 0;
      idle_cycles    = 0;
      pushes_stored  = 0;
      pushes_refused = 0;
      words_dropped  = 0;
      pops_done      = 0;
      pops_empty     = 0;
      idle_pct       = 0;
      stall_pct      = 0;
      row_known      = 1'b0;
      none           = '0;
      row_result     = none;
      prev_word      = '0;

      // Reset state first, then the change filter against the zero last word,
      // then the extremes, an empty pop, a fill past full and a drain of the oldest.
      directed_rows.push_back(make_row(CMD_POP,  16'h0000, 1'b1, STATUS_ERR, 16'h0000, 4'd0));
      directed_rows.push_back(make_row(CMD_PUSH, 16'h0000, 1'b1, STATUS_ERR, 16'h0000, 4'd0));
      directed_rows.push_back(make_row(CMD_PUSH, 16'hFFFF, 1'b1, STATUS_OK,  16'h0000, 4'd1));
      directed_rows.push_back(make_row(CMD_PUSH, 16'hFFFF, 1'b1, STATUS_ERR, 16'h0000, 4'd1));
      directed_rows.push_back(make_row(CMD_PUSH, 16'h0000, 1'b1, STATUS_OK,  16'h0000, 4'd2));
      directed_rows.push_back(make_row(CMD_POP,  16'hFFFF, 1'b1, STATUS_OK,  16'hFFFF, 4'd1));
      directed_rows.push_back(make_row(CMD_POP,  16'h1234, 1'b1, STATUS_OK,  16'h0000, 4'd0));
      directed_rows.push_back(make_row(CMD_POP,  16'h0000, 1'b1, STATUS_ERR, 16'h0000, 4'd0));
      directed_rows.push_back(make_row(CMD_PUSH, 16'h0000, 1'b1, STATUS_ERR, 16'h0000, 4'd0));
      for (int i = 0; i < DEPTH; i++)
         directed_rows.push_back(make_row(CMD_PUSH, 16'h0001 << i, 1'b0, STATUS_OK, '0, '0));
      directed_rows.push_back(make_row(CMD_PUSH, 16'h8000, 1'b0, STATUS_OK, '0, '0));
      directed_rows.push_back(make_row(CMD_PUSH, 16'hAAAA, 1'b0, STATUS_OK, '0, '0));
      directed_rows.push_back(make_row(CMD_PUSH, 16'h5555, 1'b0, STATUS_OK, '0, '0));
      for (int i = 0; i < 3; i++)
         directed_rows.push_back(make_row(CMD_POP, 16'h0000, 1'b0, STATUS_OK, '0, '0));

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_request(directed_rows[i].command, directed_rows[i].buttons,
                      directed_rows[i].known, directed_rows[i].result);
      wait_for_drain();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 75; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 75; end
            default: begin idle_pct = 6; stall_pct = 6; end
         endcase
         push_pct = 55;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // Shift the push/pop balance in bursts so the queue swings between full and empty.
            if (n % 20 == 0) begin
               pick = $urandom_range(0, 2);
               push_pct = (pick == 0) ? 30 : (pick == 1) ? 55 : 85;
               // Run some bursts with no sender gaps even in idle phases.
               if (phase == 1) idle_pct = ($urandom_range(0, 3) == 0) ? 0 : 75;
            end
            if ($urandom_range(0, 99) < push_pct) begin
               pick = $urandom_range(0, 9);
               if (pick == 0)      word = prev_word;
               else if (pick == 1) word = 16'h0000;
               else if (pick == 2) word = 16'hFFFF;
               else                word = 16'($urandom_range(0, 65535));
               prev_word = word;
               send_request(CMD_PUSH, word, 1'b0, none);
            end else begin
               send_request(CMD_POP, 16'($urandom_range(0, 65535)), 1'b0, none);
            end
         end
         // Let the queue catch up completely before the next phase.
         wait_for_drain();
      end

      repeat (10) @(posedge clock);
      $display("Covered %0d stored and %0d refused pushes, %0d words dropped when full,",
               pushes_stored, pushes_refused, words_dropped);
      $display("%0d pops returning a word and %0d empty pops; %0d mismatches.",
               pops_done, pops_empty, mismatches);
      if (mismatches == 0 && pending_responses.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
